@@ design/eeg_pkg.sv @@
// Shared constants, types and helpers for the extended Euclid GCD block.
package eeg_pkg;

  // Operand and coefficient width
  localparam int unsigned WIDTH = 32;
  // Magnitude and divisor width
  localparam int unsigned MAG_W = WIDTH - 1;
  // Alignment shift count width
  localparam int unsigned SHIFT_W = $clog2(MAG_W);
  // Stream data widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = ((2 * WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((MAG_W + 2 * WIDTH + 7) / 8) * 8;
  // Full product width of quotient times coefficient
  localparam int unsigned PROD_W = MAG_W + WIDTH;

  // Result of the shared compare and subtract unit
  typedef struct packed {
    logic             ge;    // minuend is not below subtrahend
    logic [MAG_W-1:0] diff;  // low bits of the difference
  } sub_res_t;

  // Magnitude of a two's complement operand; the most negative value saturates
  function automatic logic [MAG_W-1:0] magnitude(logic [WIDTH-1:0] raw);
    logic [WIDTH-1:0] neg;
    neg = -raw;
    if (!raw[WIDTH-1]) begin
      return raw[MAG_W-1:0];
    end else if (raw == {1'b1, {MAG_W{1'b0}}}) begin
      return {MAG_W{1'b1}};
    end else begin
      return neg[MAG_W-1:0];
    end
  endfunction

endpackage

@@ design/extended_euclid_gcd.sv @@
// Top level of the extended Euclid GCD block: sequencer and working registers.
//
// Slave stream: tdata carries value_a and value_b, two's complement operands
// whose magnitudes are used. Master stream: tdata carries divisor, the gcd of
// the magnitudes, with Bezout coefficients coef_a and coef_b such that
// |value_a|*coef_a + |value_b|*coef_b = divisor.
// One transfer in gives exactly one transfer out. After an input transfer the
// block is busy: tready stays low until the result has been placed in the
// output register. Each quotient step of the Euclid recursion runs a shift
// up and shift down restoring division on one shared compare and subtract
// unit, then the two coefficient updates in turn on one shared multiplier,
// then a test of the new remainder.
// A result waiting in the output register does not stop the next input
// transfer; the next result waits in the sequencer until the receiver takes
// the previous one. Reset empties the output register and returns the
// sequencer to idle with tready high.
module extended_euclid_gcd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // value_a [WIDTH-1:0], value_b [2*WIDTH-1:WIDTH]
  input  logic [eeg_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // divisor [MAG_W-1:0], coef_a next WIDTH bits, coef_b next WIDTH bits, zero pad
  output logic [eeg_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UP,
    ST_DOWN,
    ST_MUL_S,
    ST_MUL_T,
    ST_DONE
  } state_e;

  localparam int unsigned PAD_W = eeg_pkg::OUT_DATA_W - eeg_pkg::MAG_W - 2 * eeg_pkg::WIDTH;

  state_e                        state_q;
  logic [eeg_pkg::MAG_W-1:0]     r0_q, r1_q, dsr_q, quot_q;
  logic [eeg_pkg::SHIFT_W-1:0]   shift_q;
  logic [eeg_pkg::WIDTH-1:0]     s0_q, s1_q, t0_q, t1_q;
  logic                          swap_q;
  logic                          out_valid_q;
  logic [eeg_pkg::OUT_DATA_W-1:0] out_data_q;

  logic [eeg_pkg::MAG_W-1:0]     mag_a, mag_b;
  logic [eeg_pkg::MAG_W:0]       sub_operand;
  eeg_pkg::sub_res_t             sub_res;
  logic [eeg_pkg::WIDTH-1:0]     mac_acc, mac_coef, mac_res;
  logic                          in_xfer;
  logic                          out_free;
  logic [eeg_pkg::WIDTH-1:0]     res_coef_a, res_coef_b;

  assign mag_a    = eeg_pkg::magnitude(s_axis_tdata_i[eeg_pkg::WIDTH-1:0]);
  assign mag_b    = eeg_pkg::magnitude(s_axis_tdata_i[2*eeg_pkg::WIDTH-1:eeg_pkg::WIDTH]);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Compare against the doubled divisor while aligning, the divisor itself after
  assign sub_operand = (state_q == ST_UP) ? {dsr_q, 1'b0} : {1'b0, dsr_q};

  eeg_sub_unit u_sub (
    .minuend_i    (r0_q),
    .subtrahend_i (sub_operand),
    .res_o        (sub_res)
  );

  // Share the multiplier between the s and t updates
  assign mac_acc  = (state_q == ST_MUL_T) ? t0_q : s0_q;
  assign mac_coef = (state_q == ST_MUL_T) ? t1_q : s1_q;

  eeg_mac_unit u_mac (
    .acc_i  (mac_acc),
    .quot_i (quot_q),
    .coef_i (mac_coef),
    .res_o  (mac_res)
  );

  // Map coefficients of the larger and smaller magnitude back to the operands
  assign res_coef_a = swap_q ? t0_q : s0_q;
  assign res_coef_b = swap_q ? s0_q : t0_q;

  // Sequencer, working registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      r0_q        <= '0;
      r1_q        <= '0;
      dsr_q       <= '0;
      quot_q      <= '0;
      shift_q     <= '0;
      s0_q        <= '0;
      s1_q        <= '0;
      t0_q        <= '0;
      t1_q        <= '0;
      swap_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // Drop a taken result unless the sequencer refills the register now
      if (out_valid_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            // Larger magnitude is the dividend; both zero gives zero coefficients
            swap_q <= !(mag_a > mag_b);
            if (mag_a > mag_b) begin
              r0_q <= mag_a;
              r1_q <= mag_b;
            end else begin
              r0_q <= mag_b;
              r1_q <= mag_a;
            end
            s0_q    <= eeg_pkg::WIDTH'((mag_a != '0) || (mag_b != '0));
            s1_q    <= '0;
            t0_q    <= '0;
            t1_q    <= eeg_pkg::WIDTH'(1);
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          dsr_q   <= r1_q;
          shift_q <= '0;
          quot_q  <= '0;
          state_q <= (r1_q == '0) ? ST_DONE : ST_UP;
        end
        ST_UP: begin
          // Align the divisor under the leading bit of the dividend
          if (sub_res.ge) begin
            dsr_q   <= {dsr_q[eeg_pkg::MAG_W-2:0], 1'b0};
            shift_q <= shift_q + 1'b1;
          end else begin
            state_q <= ST_DOWN;
          end
        end
        ST_DOWN: begin
          // Restore step: one quotient bit per cycle
          if (sub_res.ge) begin
            r0_q <= sub_res.diff;
          end
          quot_q <= {quot_q[eeg_pkg::MAG_W-2:0], sub_res.ge};
          if (shift_q == '0) begin
            state_q <= ST_MUL_S;
          end else begin
            dsr_q   <= {1'b0, dsr_q[eeg_pkg::MAG_W-1:1]};
            shift_q <= shift_q - 1'b1;
          end
        end
        ST_MUL_S: begin
          s0_q    <= s1_q;
          s1_q    <= mac_res;
          state_q <= ST_MUL_T;
        end
        ST_MUL_T: begin
          // Advance the recursion: remainder becomes the new divisor
          t0_q    <= t1_q;
          t1_q    <= mac_res;
          r0_q    <= r1_q;
          r1_q    <= r0_q;
          state_q <= ST_CHECK;
        end
        ST_DONE: begin
          // Hold the result until the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {{PAD_W{1'b0}}, res_coef_b, res_coef_a, r0_q};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

@@ design/eeg_sub_unit.sv @@
// Shared compare and subtract unit for the remainder datapath.
module eeg_sub_unit (
  input  logic [eeg_pkg::MAG_W-1:0] minuend_i,
  input  logic [eeg_pkg::MAG_W:0]   subtrahend_i,
  output eeg_pkg::sub_res_t         res_o
);

  logic [eeg_pkg::MAG_W+1:0] wide_diff;

  // Subtract with one guard bit; the top bit is the borrow
  assign wide_diff = {2'b00, minuend_i} - {1'b0, subtrahend_i};

  assign res_o.ge   = ~wide_diff[eeg_pkg::MAG_W+1];
  assign res_o.diff = wide_diff[eeg_pkg::MAG_W-1:0];

endmodule

@@ design/eeg_mac_unit.sv @@
// Shared multiply and subtract unit for the Bezout coefficient update.
module eeg_mac_unit (
  input  logic [eeg_pkg::WIDTH-1:0] acc_i,
  input  logic [eeg_pkg::MAG_W-1:0] quot_i,
  input  logic [eeg_pkg::WIDTH-1:0] coef_i,
  output logic [eeg_pkg::WIDTH-1:0] res_o
);

  logic [eeg_pkg::PROD_W-1:0] prod;

  // Coefficients wrap modulo 2^WIDTH, so only the low product bits matter
  assign prod  = eeg_pkg::PROD_W'(quot_i) * eeg_pkg::PROD_W'(coef_i);
  assign res_o = acc_i - prod[eeg_pkg::WIDTH-1:0];

endmodule

@@ design/eeg_checker.sv @@
// Port-level checker for the extended Euclid GCD block, bound to the top level.
module eeg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic [eeg_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [eeg_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i
);

  localparam int unsigned CA_LO = eeg_pkg::MAG_W;
  localparam int unsigned CB_LO = eeg_pkg::MAG_W + eeg_pkg::WIDTH;

  // No result is offered once reset has been seen at an edge
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result offered during reset");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed or dropped");

  // Drop ready for the cycle after an input transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
      s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready high straight after an input transfer");

  // A zero divisor comes only with zero coefficients
  a_zero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o && (m_axis_tdata_o[eeg_pkg::MAG_W-1:0] == '0) |->
      (m_axis_tdata_o[CA_LO +: eeg_pkg::WIDTH] == '0) &&
      (m_axis_tdata_o[CB_LO +: eeg_pkg::WIDTH] == '0))
    else $error("zero divisor with non-zero coefficient");

endmodule

bind extended_euclid_gcd eeg_checker u_eeg_checker (.*);
